// ===== design/cctb_pkg.sv =====
// cctb_pkg: shared types, character codes and class masks for char_class_to_bitmap.
// Used by cctb_parse, cctb_queue, cctb_emit and the top level; depends on nothing.
package cctb_pkg;

   localparam int SET_BITS    = 256;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [63:0] bitmap_word;
      logic [1:0]  word_index;
      logic        final_word;
      logic        parse_error;
   } rsp_type;

   typedef struct packed {
      logic                parse_error;
      logic [SET_BITS-1:0] bits;
   } set_type;

   typedef enum logic [2:0] {
      ESC_NONE,
      ESC_BSLASH,
      ESC_HEX0,
      ESC_HEX1,
      ESC_OCT1,
      ESC_OCT2
   } esc_phase_type;

   typedef enum logic [1:0] {
      PAT_START,
      PAT_OPENED,
      PAT_BODY
   } pat_phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic                hit;
      logic [SET_BITS-1:0] mask;
   } class_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_VT     = 8'h0b;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_F   = 8'h46;
   localparam logic [7:0] CH_UC_Z   = 8'h5a;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_CARET  = 8'h5e;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_D   = 8'h64;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_H   = 8'h68;
   localparam logic [7:0] CH_LC_L   = 8'h6c;
   localparam logic [7:0] CH_LC_N   = 8'h6e;
   localparam logic [7:0] CH_LC_O   = 8'h6f;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_S   = 8'h73;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_U   = 8'h75;
   localparam logic [7:0] CH_LC_V   = 8'h76;
   localparam logic [7:0] CH_LC_W   = 8'h77;
   localparam logic [7:0] CH_LC_X   = 8'h78;
   localparam logic [7:0] CH_LC_Y   = 8'h79;
   localparam logic [7:0] CH_LC_Z   = 8'h7a;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   function automatic logic [SET_BITS-1:0] span_mask(input logic [7:0] lo, input logic [7:0] hi);
      logic [SET_BITS-1:0] m;
      for (int k = 0; k < SET_BITS; k++) begin
         m[k] = (8'(k) >= lo) && (8'(k) <= hi);
      end
      return m;
   endfunction

   localparam logic [SET_BITS-1:0] MASK_DIGIT = span_mask(CH_ZERO, CH_NINE);
   localparam logic [SET_BITS-1:0] MASK_OCT   = span_mask(CH_ZERO, CH_SEVEN);
   localparam logic [SET_BITS-1:0] MASK_UPPER = span_mask(CH_UC_A, CH_UC_Z);
   localparam logic [SET_BITS-1:0] MASK_LOWER = span_mask(CH_LC_A, CH_LC_Z);
   localparam logic [SET_BITS-1:0] MASK_ALPHA = MASK_UPPER | MASK_LOWER;
   localparam logic [SET_BITS-1:0] MASK_HEX   = MASK_DIGIT | span_mask(CH_UC_A, CH_UC_F)
                                               | span_mask(CH_LC_A, CH_LC_F);
   localparam logic [SET_BITS-1:0] MASK_WORD  = MASK_ALPHA | MASK_DIGIT
                                               | span_mask(CH_UNDER, CH_UNDER);
   localparam logic [SET_BITS-1:0] MASK_SPACE = span_mask(CH_BS, CH_CR)
                                               | span_mask(CH_SPACE, CH_SPACE);
   localparam logic [SET_BITS-1:0] MASK_BLANK = span_mask(CH_SPACE, CH_SPACE)
                                               | span_mask(CH_TAB, CH_TAB);

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      logic [7:0] d;
      h.ok = 1'b1;
      d = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_UC_A && c <= CH_UC_F) begin
         d = c - CH_UC_A + 8'd10;
      end else if (c >= CH_LC_A && c <= CH_LC_F) begin
         d = c - CH_LC_A + 8'd10;
      end else begin
         h.ok = 1'b0;
      end
      h.value = d[3:0];
      return h;
   endfunction

   function automatic class_type class_lookup(input logic [7:0] c);
      class_type r;
      logic upper;
      logic [7:0] lc;
      logic [SET_BITS-1:0] m;
      upper = (c >= CH_UC_A) && (c <= CH_UC_Z);
      lc = upper ? (c | CASE_BIT) : c;
      r.hit = 1'b1;
      unique case (lc)
         CH_LC_H: m = MASK_HEX;
         CH_LC_D: m = MASK_DIGIT;
         CH_LC_O: m = MASK_OCT;
         CH_LC_U: m = MASK_UPPER;
         CH_LC_W: m = MASK_WORD;
         CH_LC_A: m = MASK_ALPHA;
         CH_LC_L: m = MASK_LOWER;
         CH_LC_S: m = MASK_SPACE;
         CH_LC_Y: m = MASK_BLANK;
         default: begin
            m = '0;
            r.hit = 1'b0;
         end
      endcase
      r.mask = upper ? ~m : m;
      return r;
   endfunction

   function automatic logic [7:0] escape_char(input logic [7:0] c);
      logic [7:0] e;
      unique case (c)
         CH_LC_N: e = CH_NL;
         CH_LC_R: e = CH_CR;
         CH_LC_B: e = CH_BS;
         CH_LC_T: e = CH_TAB;
         CH_LC_V: e = CH_VT;
         CH_LC_F: e = CH_FF;
         default: e = c;
      endcase
      return e;
   endfunction

endpackage

// ===== design/cctb_parse.sv =====
// cctb_parse: front end, parses one pattern byte per cycle into a 256-bit set while
// cctb_queue is not full; hands the finished set to it on the closing byte; uses cctb_pkg.
module cctb_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cctb_pkg::req_type req_word,
   input  logic              q_full,
   output logic              q_push,
   output cctb_pkg::set_type q_set
);

   logic [cctb_pkg::SET_BITS-1:0] bits_ff, bits_in;
   logic [7:0]                    rs_ff, rs_in;
   logic                          hrs_ff, hrs_in;
   logic                          rp_ff, rp_in;
   cctb_pkg::esc_phase_type       esc_ff, esc_in;
   logic [7:0]                    val_ff, val_in;
   cctb_pkg::pat_phase_type       pat_ff, pat_in;
   logic                          neg_ff, neg_in;
   logic                          done_ff, done_in;
   logic                          err_ff, err_in;

   logic                          accept;
   logic [7:0]                    c;
   logic                          go;
   logic                          p_use;
   logic                          a_use, b_use;
   logic [7:0]                    a_chr, b_chr;
   logic                          dot;
   logic                          range_on;
   logic [cctb_pkg::SET_BITS-1:0] cls_mask, a_mask, add_mask, sum, with_dash;
   cctb_pkg::hex_type             hex;
   cctb_pkg::class_type           lk;

   assign accept = req_valid && !req_stall;
   assign c      = req_word.char_code;
   assign hex    = cctb_pkg::hex_digit(c);
   assign lk     = cctb_pkg::class_lookup(c);

   // next state
   always_comb begin
      esc_in   = esc_ff;
      val_in   = val_ff;
      pat_in   = pat_ff;
      neg_in   = neg_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      rs_in    = rs_ff;
      hrs_in   = hrs_ff;
      rp_in    = rp_ff;
      a_use    = 1'b0;
      a_chr    = cctb_pkg::CH_NUL;
      b_use    = 1'b0;
      b_chr    = cctb_pkg::CH_NUL;
      p_use    = 1'b0;
      cls_mask = '0;
      dot      = 1'b0;
      go       = 1'b0;
      if (!done_ff) begin
         go = 1'b1;
         unique case (esc_ff)
            cctb_pkg::ESC_HEX0, cctb_pkg::ESC_HEX1: begin
               if (hex.ok) begin
                  go = 1'b0;
                  val_in = {val_ff[3:0], hex.value};
                  if (esc_ff == cctb_pkg::ESC_HEX0) begin
                     esc_in = cctb_pkg::ESC_HEX1;
                  end else begin
                     esc_in = cctb_pkg::ESC_NONE;
                     a_use  = 1'b1;
                     a_chr  = val_in;
                  end
               end else begin
                  esc_in = cctb_pkg::ESC_NONE;
                  a_use  = 1'b1;
                  a_chr  = val_ff;
               end
            end
            cctb_pkg::ESC_OCT1, cctb_pkg::ESC_OCT2: begin
               if (c >= cctb_pkg::CH_ZERO && c <= cctb_pkg::CH_SEVEN) begin
                  go = 1'b0;
                  val_in = {val_ff[4:0], c[2:0]};
                  if (esc_ff == cctb_pkg::ESC_OCT1) begin
                     esc_in = cctb_pkg::ESC_OCT2;
                  end else begin
                     esc_in = cctb_pkg::ESC_NONE;
                     a_use  = 1'b1;
                     a_chr  = val_in;
                  end
               end else begin
                  esc_in = cctb_pkg::ESC_NONE;
                  a_use  = 1'b1;
                  a_chr  = val_ff;
               end
            end
            cctb_pkg::ESC_BSLASH: begin
               go = 1'b0;
               esc_in = cctb_pkg::ESC_NONE;
               if (c == cctb_pkg::CH_NUL) begin
                  err_in  = 1'b1;
                  done_in = 1'b1;
               end else if (lk.hit) begin
                  cls_mask = lk.mask;
                  hrs_in   = 1'b0;
                  rp_in    = 1'b0;
               end else if (c == cctb_pkg::CH_LC_X) begin
                  val_in = 8'h00;
                  esc_in = cctb_pkg::ESC_HEX0;
               end else if (c >= cctb_pkg::CH_ZERO && c <= cctb_pkg::CH_SEVEN) begin
                  val_in = {5'b00000, c[2:0]};
                  esc_in = cctb_pkg::ESC_OCT1;
               end else begin
                  a_use = 1'b1;
                  a_chr = cctb_pkg::escape_char(c);
               end
            end
            default: begin
            end
         endcase
         if (a_use) begin
            rs_in  = a_chr;
            hrs_in = 1'b1;
            rp_in  = 1'b0;
         end
         if (go) begin
            if (pat_ff == cctb_pkg::PAT_START) begin
               if (c == cctb_pkg::CH_NUL) begin
                  done_in = 1'b1;
                  go      = 1'b0;
               end else if (c == cctb_pkg::CH_LBRACK) begin
                  pat_in = cctb_pkg::PAT_OPENED;
                  go     = 1'b0;
               end else begin
                  pat_in = cctb_pkg::PAT_BODY;
               end
            end else if (pat_ff == cctb_pkg::PAT_OPENED) begin
               pat_in = cctb_pkg::PAT_BODY;
               if (c == cctb_pkg::CH_CARET) begin
                  neg_in = 1'b1;
                  go     = 1'b0;
               end
            end
         end
         if (go) begin
            if (c == cctb_pkg::CH_NUL || c == cctb_pkg::CH_RBRACK) begin
               done_in = 1'b1;
            end else if (c == cctb_pkg::CH_DASH) begin
               if (hrs_in) begin
                  rp_in = 1'b1;
               end else begin
                  p_use = 1'b1;
               end
            end else if (c == cctb_pkg::CH_DOT) begin
               dot     = 1'b1;
               done_in = 1'b1;
            end else if (c == cctb_pkg::CH_BSLASH) begin
               esc_in = cctb_pkg::ESC_BSLASH;
            end else begin
               p_use = 1'b1;
            end
         end
         if (p_use) begin
            rs_in  = c;
            hrs_in = 1'b1;
            rp_in  = 1'b0;
            if (a_use) begin
               b_use = 1'b1;
               b_chr = c;
            end else begin
               a_use = 1'b1;
               a_chr = c;
            end
         end
      end
      // close out a pending escape on the last byte
      if (req_word.is_end && !done_in) begin
         if (esc_in == cctb_pkg::ESC_BSLASH) begin
            err_in = 1'b1;
         end else if (esc_in != cctb_pkg::ESC_NONE) begin
            a_use = 1'b1;
            a_chr = val_in;
            rp_in = 1'b0;
         end
         esc_in = cctb_pkg::ESC_NONE;
      end
   end

   assign range_on = rp_ff && hrs_ff;

   always_comb begin
      for (int k = 0; k < cctb_pkg::SET_BITS; k++) begin
         a_mask[k] = a_use && ((8'(k) == a_chr)
                     || (range_on && (8'(k) > rs_ff) && (8'(k) < a_chr)));
      end
   end

   always_comb begin
      add_mask  = a_mask | cls_mask | {cctb_pkg::SET_BITS{dot}}
                | ({{(cctb_pkg::SET_BITS-1){1'b0}}, b_use} << b_chr);
      sum       = bits_ff | add_mask;
      with_dash = sum | ({{(cctb_pkg::SET_BITS-1){1'b0}}, rp_in} << cctb_pkg::CH_DASH);
      bits_in   = sum;
   end

   // outputs
   always_comb begin
      req_stall         = q_full;
      q_push            = accept && req_word.is_end;
      q_set.parse_error = err_in;
      q_set.bits        = neg_in ? ~with_dash : with_dash;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_word.is_end)) begin
         bits_ff <= '0;
         rs_ff   <= 8'h00;
         hrs_ff  <= 1'b0;
         rp_ff   <= 1'b0;
         esc_ff  <= cctb_pkg::ESC_NONE;
         val_ff  <= 8'h00;
         pat_ff  <= cctb_pkg::PAT_START;
         neg_ff  <= 1'b0;
         done_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         bits_ff <= bits_in;
         rs_ff   <= rs_in;
         hrs_ff  <= hrs_in;
         rp_ff   <= rp_in;
         esc_ff  <= esc_in;
         val_ff  <= val_in;
         pat_ff  <= pat_in;
         neg_ff  <= neg_in;
         done_ff <= done_in;
         err_ff  <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.is_end) |=> (esc_ff == cctb_pkg::ESC_NONE)
         && (pat_ff == cctb_pkg::PAT_START) && !done_ff && !err_ff && (bits_ff == '0))
      else $error("parser state not cleared after closing byte");
`endif

endmodule

// ===== design/cctb_queue.sv =====
// cctb_queue: two-entry queue of finished sets between parser and emitter.
// Uses cctb_pkg for the entry type.
module cctb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cctb_pkg::set_type push_set,
   output logic              full,
   output logic              valid,
   output cctb_pkg::set_type head,
   input  logic              pop
);

   localparam int PTR_BITS = $clog2(cctb_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(cctb_pkg::QUEUE_DEPTH + 1);

   cctb_pkg::set_type   mem_ff [cctb_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      full  = count_ff == CNT_BITS'(cctb_pkg::QUEUE_DEPTH);
      valid = count_ff != '0;
      head  = mem_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(cctb_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(cctb_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("set pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("set popped from empty queue");
`endif

endmodule

// ===== design/cctb_emit.sv =====
// cctb_emit: back end, slices the head set into result words behind an output register.
// Reads cctb_queue; uses cctb_pkg.
module cctb_emit #(
   parameter int OUT_WORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cctb_pkg::set_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cctb_pkg::rsp_type rsp_word
);

   localparam int NWORDS   = cctb_pkg::SET_BITS / OUT_WORD_BITS;
   localparam int CNT_BITS = $clog2(NWORDS);
   localparam int LAST     = NWORDS - 1;
   localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - OUT_WORD_BITS);

   logic [CNT_BITS-1:0]           w_ff, w_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   cctb_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          load;
   logic                          last;
   logic [cctb_pkg::SET_BITS-1:0] shifted;

   always_comb begin
      load    = q_valid && (!rsp_valid_ff || !rsp_stall);
      last    = w_ff == CNT_BITS'(LAST);
      q_pop   = load && last;
      shifted = q_head.bits >> (w_ff * OUT_WORD_BITS);
      rsp_in.bitmap_word = shifted[63:0] & WORD_MASK;
      rsp_in.word_index  = w_ff[1:0];
      rsp_in.final_word  = last;
      rsp_in.parse_error = q_head.parse_error;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         w_in         = last ? '0 : w_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.final_word) |-> (rsp_word.word_index == 2'(LAST)))
      else $error("final word flagged at wrong index");
`endif

endmodule

// ===== design/char_class_to_bitmap.sv =====
// char_class_to_bitmap: top level, cctb_parse -> cctb_queue -> cctb_emit; uses cctb_pkg.
// Takes one pattern byte per cycle. The first word of a set passes through the set queue
// and the output register after the closing byte is accepted, then one word per cycle while
// rsp_stall is low, 256/OUT_WORD_BITS words a set. The parser stalls only while the two-entry
// set queue is full, which the emitter's word rate sets for patterns shorter than the word count.
// Synchronous reset clears parser state, queue pointers and the output valid.
module char_class_to_bitmap #(
   parameter int OUT_WORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cctb_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cctb_pkg::rsp_type rsp_word
);

   logic              q_push;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;
   cctb_pkg::set_type q_set;
   cctb_pkg::set_type q_head;

   cctb_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_set     (q_set)
   );

   cctb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_set (q_set),
      .full     (q_full),
      .valid    (q_valid),
      .head     (q_head),
      .pop      (q_pop)
   );

   cctb_emit #(
      .OUT_WORD_BITS (OUT_WORD_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== bench/char_class_to_bitmap_tb.sv =====
// char_class_to_bitmap_tb: self-checking bench for char_class_to_bitmap.
// Feeds directed and random class patterns, predicts each 256-bit set in a scoreboard
// class and checks every word; depends on cctb_pkg and the char_class_to_bitmap RTL.
module char_class_to_bitmap_tb;

   localparam int ITEM_COUNT  = 170;
   localparam int HOLD_CYCLES = 100;
   localparam int STUCK_LIMIT = 1000;
   localparam int SET_WORDS   = 4;

   class set_scoreboard;
      logic [255:0]            members;
      logic [7:0]              range_lo;
      bit                      range_lo_ok;
      bit                      dash_pending;
      cctb_pkg::esc_phase_type esc;
      logic [7:0]              esc_acc;
      cctb_pkg::pat_phase_type pat;
      bit                      invert;
      bit                      stopped;
      bit                      bad_tail;
      cctb_pkg::rsp_type       expected_words[$];
      int                      mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         members      = '0;
         range_lo     = 8'h00;
         range_lo_ok  = 1'b0;
         dash_pending = 1'b0;
         esc          = cctb_pkg::ESC_NONE;
         esc_acc      = 8'h00;
         pat          = cctb_pkg::PAT_START;
         invert       = 1'b0;
         stopped      = 1'b0;
         bad_tail     = 1'b0;
      endfunction

      function logic [255:0] span_bits(int lo, int hi);
         logic [255:0] m;
         m = '0;
         for (int c = lo; c <= hi && c < 256; c++) m[c] = 1'b1;
         return m;
      endfunction

      function int nibble(logic [7:0] c);
         if (c >= cctb_pkg::CH_ZERO && c <= cctb_pkg::CH_NINE)
            return int'(c) - int'(cctb_pkg::CH_ZERO);
         if (c >= cctb_pkg::CH_UC_A && c <= cctb_pkg::CH_UC_F)
            return int'(c) - int'(cctb_pkg::CH_UC_A) + 10;
         if (c >= cctb_pkg::CH_LC_A && c <= cctb_pkg::CH_LC_F)
            return int'(c) - int'(cctb_pkg::CH_LC_A) + 10;
         return -1;
      endfunction

      function void add_byte(logic [7:0] c);
         if (dash_pending && range_lo_ok && int'(c) > int'(range_lo) + 1)
            members |= span_bits(int'(range_lo) + 1, int'(c) - 1);
         members[c]   = 1'b1;
         range_lo     = c;
         range_lo_ok  = 1'b1;
         dash_pending = 1'b0;
      endfunction

      function bit add_shorthand(logic [7:0] e);
         logic [7:0]   lc;
         logic [255:0] m;
         lc = (e >= cctb_pkg::CH_UC_A && e <= cctb_pkg::CH_UC_Z) ? (e | cctb_pkg::CASE_BIT) : e;
         case (lc)
            cctb_pkg::CH_LC_H: m = span_bits(cctb_pkg::CH_UC_A, cctb_pkg::CH_UC_F)
                                   | span_bits(cctb_pkg::CH_LC_A, cctb_pkg::CH_LC_F)
                                   | span_bits(cctb_pkg::CH_ZERO, cctb_pkg::CH_NINE);
            cctb_pkg::CH_LC_D: m = span_bits(cctb_pkg::CH_ZERO, cctb_pkg::CH_NINE);
            cctb_pkg::CH_LC_O: m = span_bits(cctb_pkg::CH_ZERO, cctb_pkg::CH_SEVEN);
            cctb_pkg::CH_LC_U: m = span_bits(cctb_pkg::CH_UC_A, cctb_pkg::CH_UC_Z);
            cctb_pkg::CH_LC_W: m = span_bits(cctb_pkg::CH_UNDER, cctb_pkg::CH_UNDER)
                                   | span_bits(cctb_pkg::CH_ZERO, cctb_pkg::CH_NINE)
                                   | span_bits(cctb_pkg::CH_UC_A, cctb_pkg::CH_UC_Z)
                                   | span_bits(cctb_pkg::CH_LC_A, cctb_pkg::CH_LC_Z);
            cctb_pkg::CH_LC_A: m = span_bits(cctb_pkg::CH_UC_A, cctb_pkg::CH_UC_Z)
                                   | span_bits(cctb_pkg::CH_LC_A, cctb_pkg::CH_LC_Z);
            cctb_pkg::CH_LC_L: m = span_bits(cctb_pkg::CH_LC_A, cctb_pkg::CH_LC_Z);
            cctb_pkg::CH_LC_S: m = span_bits(cctb_pkg::CH_BS, cctb_pkg::CH_CR)
                                   | span_bits(cctb_pkg::CH_SPACE, cctb_pkg::CH_SPACE);
            cctb_pkg::CH_LC_Y: m = span_bits(cctb_pkg::CH_SPACE, cctb_pkg::CH_SPACE)
                                   | span_bits(cctb_pkg::CH_TAB, cctb_pkg::CH_TAB);
            default: return 1'b0;
         endcase
         members      |= (e != lc) ? ~m : m;
         range_lo_ok  = 1'b0;
         dash_pending = 1'b0;
         return 1'b1;
      endfunction

      function void take_escape(logic [7:0] e);
         esc = cctb_pkg::ESC_NONE;
         if (add_shorthand(e)) return;
         case (e)
            cctb_pkg::CH_LC_N: add_byte(cctb_pkg::CH_NL);
            cctb_pkg::CH_LC_R: add_byte(cctb_pkg::CH_CR);
            cctb_pkg::CH_LC_B: add_byte(cctb_pkg::CH_BS);
            cctb_pkg::CH_LC_T: add_byte(cctb_pkg::CH_TAB);
            cctb_pkg::CH_LC_V: add_byte(cctb_pkg::CH_VT);
            cctb_pkg::CH_LC_F: add_byte(cctb_pkg::CH_FF);
            cctb_pkg::CH_LC_X: begin
               esc_acc = 8'h00;
               esc     = cctb_pkg::ESC_HEX0;
            end
            default: begin
               if (e >= cctb_pkg::CH_ZERO && e <= cctb_pkg::CH_SEVEN) begin
                  esc_acc = e - cctb_pkg::CH_ZERO;
                  esc     = cctb_pkg::ESC_OCT1;
               end else begin
                  add_byte(e);
               end
            end
         endcase
      endfunction

      function void flush_number();
         if (esc != cctb_pkg::ESC_NONE && esc != cctb_pkg::ESC_BSLASH) begin
            esc = cctb_pkg::ESC_NONE;
            add_byte(esc_acc);
         end
      endfunction

      function void feed(logic [7:0] c);
         int h;
         if (stopped) return;
         if (esc == cctb_pkg::ESC_HEX0 || esc == cctb_pkg::ESC_HEX1) begin
            h = nibble(c);
            if (h >= 0) begin
               esc_acc = {esc_acc[3:0], 4'(h)};
               if (esc == cctb_pkg::ESC_HEX0) begin
                  esc = cctb_pkg::ESC_HEX1;
                  return;
               end
               esc = cctb_pkg::ESC_NONE;
               add_byte(esc_acc);
               return;
            end
            flush_number();
         end else if (esc == cctb_pkg::ESC_OCT1 || esc == cctb_pkg::ESC_OCT2) begin
            if (c >= cctb_pkg::CH_ZERO && c <= cctb_pkg::CH_SEVEN) begin
               esc_acc = {esc_acc[4:0], c[2:0]};
               if (esc == cctb_pkg::ESC_OCT1) begin
                  esc = cctb_pkg::ESC_OCT2;
                  return;
               end
               esc = cctb_pkg::ESC_NONE;
               add_byte(esc_acc);
               return;
            end
            flush_number();
         end else if (esc == cctb_pkg::ESC_BSLASH) begin
            if (c == cctb_pkg::CH_NUL) begin
               bad_tail = 1'b1;
               stopped  = 1'b1;
               esc      = cctb_pkg::ESC_NONE;
               return;
            end
            take_escape(c);
            return;
         end

         if (pat == cctb_pkg::PAT_START) begin
            if (c == cctb_pkg::CH_NUL) begin
               stopped = 1'b1;
               return;
            end
            if (c == cctb_pkg::CH_LBRACK) begin
               pat = cctb_pkg::PAT_OPENED;
               return;
            end
            pat = cctb_pkg::PAT_BODY;
         end else if (pat == cctb_pkg::PAT_OPENED) begin
            pat = cctb_pkg::PAT_BODY;
            if (c == cctb_pkg::CH_CARET) begin
               invert = 1'b1;
               return;
            end
         end

         if (c == cctb_pkg::CH_NUL || c == cctb_pkg::CH_RBRACK) begin
            stopped = 1'b1;
         end else if (c == cctb_pkg::CH_DASH) begin
            if (range_lo_ok) dash_pending = 1'b1;
            else add_byte(cctb_pkg::CH_DASH);
         end else if (c == cctb_pkg::CH_DOT) begin
            members = '1;
            stopped = 1'b1;
         end else if (c == cctb_pkg::CH_BSLASH) begin
            esc = cctb_pkg::ESC_BSLASH;
         end else begin
            add_byte(c);
         end
      endfunction

      function void note_input(cctb_pkg::req_type r);
         cctb_pkg::rsp_type w;
         feed(r.char_code);
         if (!r.is_end) return;
         if (!stopped) begin
            if (esc == cctb_pkg::ESC_BSLASH) begin
               bad_tail = 1'b1;
               esc      = cctb_pkg::ESC_NONE;
            end
            flush_number();
         end
         if (dash_pending) members[cctb_pkg::CH_DASH] = 1'b1;
         if (invert) members = ~members;
         for (int i = 0; i < SET_WORDS; i++) begin
            w.bitmap_word = members[i*64 +: 64];
            w.word_index  = 2'(i);
            w.final_word  = (i == SET_WORDS - 1);
            w.parse_error = bad_tail;
            expected_words.push_back(w);
         end
         clear();
      endfunction

      function void check_word(cctb_pkg::rsp_type got);
         cctb_pkg::rsp_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected word %h", got);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         if (got.bitmap_word !== want.bitmap_word) begin
            $error("bitmap_word expected %h actual %h", want.bitmap_word, got.bitmap_word);
            mismatches++;
         end
         if (got.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
            mismatches++;
         end
         if (got.final_word !== want.final_word) begin
            $error("final_word expected %b actual %b", want.final_word, got.final_word);
            mismatches++;
         end
         if (got.parse_error !== want.parse_error) begin
            $error("parse_error expected %b actual %b", want.parse_error, got.parse_error);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cctb_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cctb_pkg::rsp_type rsp_word;

   set_scoreboard sb = new();
   logic [7:0]    pat_q[$];
   int            sent_items = 0;
   bit            calm       = 1'b0;
   bit            hold_rsp   = 1'b0;
   int            stuck_cycles = 0;

   char_class_to_bitmap i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 16);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   function logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function void make_pattern();
      string plain;
      string hexch;
      string octch;
      plain = "acemxzAGMZ0159_ ~!";
      hexch = "0123456789abcdefABCDEFgG";
      octch = "01234567";
      pat_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) pat_q.push_back(8'($urandom));
         return;
      end
      if ($urandom_range(0, 9) < 7) begin
         pat_q.push_back(cctb_pkg::CH_LBRACK);
         if ($urandom_range(0, 9) < 4) pat_q.push_back(cctb_pkg::CH_CARET);
      end
      if ($urandom_range(0, 7) == 0) pat_q.push_back(cctb_pkg::CH_DASH);
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(0, 11))
            0, 1: pat_q.push_back(pick(plain));
            2:    pat_q.push_back(8'($urandom));
            3, 4: begin
               pat_q.push_back(pick(plain));
               pat_q.push_back(cctb_pkg::CH_DASH);
               pat_q.push_back(pick(plain));
            end
            5: begin
               pat_q.push_back(cctb_pkg::CH_BSLASH);
               pat_q.push_back(pick("nrbtvf"));
            end
            6, 7: begin
               pat_q.push_back(cctb_pkg::CH_BSLASH);
               pat_q.push_back(pick("hdouwalsyHDOUWALSY"));
            end
            8: begin
               pat_q.push_back(cctb_pkg::CH_BSLASH);
               pat_q.push_back(cctb_pkg::CH_LC_X);
               repeat ($urandom_range(0, 2)) pat_q.push_back(pick(hexch));
            end
            9: begin
               pat_q.push_back(cctb_pkg::CH_BSLASH);
               repeat ($urandom_range(1, 3)) pat_q.push_back(pick(octch));
            end
            10: begin
               pat_q.push_back(cctb_pkg::CH_BSLASH);
               pat_q.push_back(8'($urandom));
            end
            default: pat_q.push_back(cctb_pkg::CH_DASH);
         endcase
      end
      case ($urandom_range(0, 19))
         0: pat_q.push_back(cctb_pkg::CH_DOT);
         1: pat_q.push_back(cctb_pkg::CH_BSLASH);
         2: pat_q.push_back(cctb_pkg::CH_NUL);
         3, 4, 5, 6, 7, 8, 9, 10, 11: begin
            pat_q.push_back(cctb_pkg::CH_RBRACK);
            repeat ($urandom_range(0, 2)) pat_q.push_back(8'($urandom));
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(cctb_pkg::req_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_input(w);
      sent_items++;
      if (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_pattern();
      cctb_pkg::req_type w;
      for (int i = 0; i < pat_q.size(); i++) begin
         w.char_code = pat_q[i];
         w.is_end    = (i == pat_q.size() - 1);
         send_word(w);
      end
   endtask

   task automatic send_text(string s);
      pat_q.delete();
      for (int i = 0; i < s.len(); i++) pat_q.push_back(s[i]);
      send_pattern();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      bit pressed;
      pressed = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("[^-a-c\\W]");
      send_text("\\x41\\777-");
      send_text(".");
      send_text("a\\");
      pat_q = '{8'hFF, cctb_pkg::CH_NUL};
      send_pattern();
      drain();

      while (sent_items < ITEM_COUNT) begin
         calm = (sent_items >= 60 && sent_items < 100);
         if (!pressed && sent_items >= 120) begin
            drain();
            hold_rsp = 1'b1;
            repeat (8) begin
               pat_q = '{8'($urandom)};
               send_pattern();
            end
            drain();
            pressed = 1'b1;
         end
         make_pattern();
         send_pattern();
      end
      calm = 1'b0;
      drain();
      repeat (8) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
